[hw/rtl/lsag_pkg.sv]
// Shared types, codes and constants of the LED strip animation generator.
`timescale 1ns / 1ps
package lsag_pkg;

	typedef enum logic [1:0] {
		ACT_ADVANCE,
		ACT_QUERY,
		ACT_PAL_WRITE,
		ACT_RESTART
	} action_t;

	localparam logic [2:0] ANIM_OFF    = 3'd0;
	localparam logic [2:0] ANIM_STATIC = 3'd1;
	localparam logic [2:0] ANIM_FADE   = 3'd2;
	localparam logic [2:0] ANIM_SNAKE  = 3'd3;
	localparam logic [2:0] ANIM_SWAP   = 3'd4;

	localparam logic [1:0] REG_ANIMATION    = 2'd0;
	localparam logic [1:0] REG_PALETTE_SIZE = 2'd1;
	localparam logic [1:0] REG_FADE_STEPS   = 2'd2;
	localparam logic [1:0] REG_STATIC_COLOR = 2'd3;

	localparam int          CH_W     = 8;
	localparam int          PROD_W   = 18;
	localparam int          STEPS_W  = 10;
	localparam int          COLOR_W  = 24;
	localparam logic [23:0] STATIC_RESET = 24'h0000FF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SEGLEN,
		ST_SEGCHK,
		ST_SEG,
		ST_FROM,
		ST_TO,
		ST_MUL,
		ST_FDIV,
		ST_RDRES,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		K_ZERO,
		K_STATIC,
		K_FADE,
		K_SNAKE,
		K_SWAP
	} kind_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_CP,
		RD_NX,
		RD_SEG,
		RD_SWAP
	} rd_sel_t;

	typedef enum logic [2:0] {
		RES_HOLD,
		RES_ZERO,
		RES_STATIC,
		RES_RAM,
		RES_FADE
	} res_sel_t;

	typedef enum logic [1:0] {
		DIV_SEGLEN,
		DIV_SEG,
		DIV_FADE
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     adv;
		logic     restart;
		logic     pal_wr;
		logic     rd_en;
		rd_sel_t  rd_sel;
		res_sel_t res_sel;
		logic     cap_from;
		logic     mul;
		logic     div_go;
		div_sel_t div_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  div_busy;
		logic  seglen_zero;
	} sts_t;

	typedef struct packed {
		logic [2:0]  animation;
		logic [3:0]  palette_size;
		logic [9:0]  fade_steps;
		logic [23:0] static_color;
	} cfg_t;

	function automatic logic [23:0] pal_reset(input logic [3:0] idx);
		logic [23:0] v;
		case (idx)
			4'd0: v = 24'hFF0000;
			4'd1: v = 24'hFFA500;
			4'd2: v = 24'hFFFF00;
			4'd3: v = 24'h008000;
			4'd4: v = 24'h0000FF;
			4'd5: v = 24'h4B0082;
			4'd6: v = 24'hEE82EE;
			default: v = 24'h000000;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/lsag_item_if.sv]
// Input item channel: valid/ready plus the item payload.
`timescale 1ns / 1ps
interface lsag_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [8:0]  pixel_index;
	logic [2:0]  palette_slot;
	logic [23:0] palette_color;

	modport source (output valid, output action, output pixel_index, output palette_slot,
		output palette_color, input ready);
	modport sink (input valid, input action, input pixel_index, input palette_slot,
		input palette_color, output ready);
endinterface

[hw/rtl/lsag_result_if.sv]
// Result channel: valid/ready plus the pixel color.
`timescale 1ns / 1ps
interface lsag_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[hw/rtl/lsag_div.sv]
// Three-lane restoring divider with a shared divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module lsag_div #(
	parameter int DW = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [2:0][DW-1:0]   dividend,
	input  logic [DW-1:0]        divisor,
	output logic [2:0][DW-1:0]   quotient,
	output logic                 busy
);
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0]       cnt_q;
	logic [2:0][DW-1:0]  rem_q;
	logic [2:0][DW-1:0]  quo_q;
	logic [DW-1:0]       dvs_q;
	logic [2:0][DW-1:0]  rem_d;
	logic [2:0][DW-1:0]  quo_d;

	always_comb begin
		logic [DW:0] r2;
		logic        ge;
		for (int c = 0; c < 3; c++) begin
			r2 = {rem_q[c], quo_q[c][DW-1]};
			ge = (r2 >= {1'b0, dvs_q});
			rem_d[c] = ge ? DW'(r2 - {1'b0, dvs_q}) : DW'(r2);
			quo_d[c] = {quo_q[c][DW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign quotient = quo_q;
	assign busy     = (cnt_q != '0);
endmodule

[hw/rtl/lsag_dp.sv]
// Datapath: palette memory, animation state, fade multiply and division, result registers.
`timescale 1ns / 1ps
module lsag_dp #(
	parameter int LED_COUNT     = 300,
	parameter int PALETTE_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsag_pkg::cmd_t     cmd,
	input  lsag_pkg::cfg_t     cfg,
	input  logic [8:0]         pixel_index,
	input  logic [2:0]         palette_slot,
	input  logic [23:0]        palette_color,
	output lsag_pkg::sts_t     sts,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);
	localparam int PW     = $clog2(PALETTE_DEPTH);
	localparam int SZ_W   = $clog2(PALETTE_DEPTH + 1);
	localparam int OFF_W  = $clog2(LED_COUNT);
	localparam int REL_B  = $clog2(2 * LED_COUNT);
	localparam int SUM_W  = (REL_B > 9 ? REL_B : 9) + 1;
	localparam int DW     = (SUM_W > lsag_pkg::PROD_W) ? SUM_W : lsag_pkg::PROD_W;

	// palette store
	logic [23:0]              mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] vld_q;
	logic [23:0]              rdata_q;
	logic [PW-1:0]            rd_idx;
	logic                     wr_en;
	logic [PW-1:0]            wr_addr;

	// animation state
	logic [PW-1:0]    cp_q;
	logic [9:0]       fpos_q;
	logic [OFF_W-1:0] off_q;

	// query working registers
	logic [8:0]             pix_q;
	logic [23:0]            from_q;
	logic [2:0][17:0]       prod_s1;
	logic [2:0]             dir_s1;
	logic [23:0]            from_s1;
	logic [23:0]            res_q;
	logic [7:0]             red_q;
	logic [7:0]             green_q;
	logic [7:0]             blue_q;

	logic [SZ_W-1:0]  size_eff;
	logic [9:0]       steps_eff;
	logic [PW-1:0]    cp_eff;
	logic [PW-1:0]    cp_nx;
	logic [PW-1:0]    nx;
	logic [9:0]       j;
	logic [9:0]       fp1;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] rel;
	logic             oor;
	logic [23:0]      fade_res;
	lsag_pkg::kind_t  kind;

	logic [2:0][DW-1:0] dvd;
	logic [DW-1:0]      dvs;
	logic [2:0][DW-1:0] quot;
	logic               div_busy;

	always_comb begin
		if (cfg.palette_size == 4'd0)
			size_eff = SZ_W'(1);
		else if (32'(cfg.palette_size) > PALETTE_DEPTH)
			size_eff = SZ_W'(PALETTE_DEPTH);
		else
			size_eff = SZ_W'(cfg.palette_size);
	end

	assign steps_eff = (cfg.fade_steps == 10'd0) ? 10'd1 : cfg.fade_steps;
	assign cp_eff    = (SZ_W'(cp_q) < size_eff) ? cp_q : '0;
	assign cp_nx     = ((SZ_W'(cp_q) + SZ_W'(1)) >= size_eff) ? '0 : cp_q + PW'(1);
	assign nx        = ((SZ_W'(cp_eff) + SZ_W'(1)) == size_eff) ? '0 : cp_eff + PW'(1);
	assign j         = (fpos_q > steps_eff) ? steps_eff : fpos_q;
	assign fp1       = fpos_q + 10'd1;

	assign oor = (SUM_W'(pix_q) >= SUM_W'(LED_COUNT));
	assign sum = SUM_W'(pix_q) + SUM_W'(LED_COUNT) - SUM_W'(off_q);
	assign rel = (sum >= SUM_W'(LED_COUNT)) ? sum - SUM_W'(LED_COUNT) : sum;

	always_comb begin
		if (oor) begin
			kind = lsag_pkg::K_ZERO;
		end else begin
			case (cfg.animation)
				lsag_pkg::ANIM_STATIC: kind = lsag_pkg::K_STATIC;
				lsag_pkg::ANIM_FADE:   kind = lsag_pkg::K_FADE;
				lsag_pkg::ANIM_SNAKE:  kind = lsag_pkg::K_SNAKE;
				lsag_pkg::ANIM_SWAP:   kind = lsag_pkg::K_SWAP;
				default:               kind = lsag_pkg::K_ZERO;
			endcase
		end
	end
	assign sts.kind        = kind;
	assign sts.div_busy    = div_busy;
	assign sts.seglen_zero = (quot[0] == '0);

	always_comb begin
		case (cmd.rd_sel)
			lsag_pkg::RD_CP:   rd_idx = cp_eff;
			lsag_pkg::RD_NX:   rd_idx = nx;
			lsag_pkg::RD_SEG:  rd_idx = (quot[0] >= DW'(size_eff)) ? '0 : PW'(quot[0]);
			lsag_pkg::RD_SWAP: rd_idx = (size_eff < SZ_W'(2)) ? '0 : cp_eff;
			default:           rd_idx = '0;
		endcase
	end

	assign wr_en   = cmd.pal_wr && (32'(palette_slot) < PALETTE_DEPTH);
	assign wr_addr = PW'(palette_slot);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= palette_color;
		if (cmd.rd_en)
			rdata_q <= vld_q[rd_idx] ? mem[rd_idx] : lsag_pkg::pal_reset(4'(rd_idx));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q   <= '0;
			fpos_q <= 10'd1;
			off_q  <= '0;
		end else if (cmd.restart) begin
			cp_q   <= '0;
			fpos_q <= 10'd1;
			off_q  <= '0;
		end else if (cmd.adv) begin
			case (cfg.animation)
				lsag_pkg::ANIM_FADE: begin
					if (fp1 > steps_eff || fp1 == 10'd0) begin
						fpos_q <= 10'd1;
						cp_q   <= cp_nx;
					end else begin
						fpos_q <= fp1;
					end
				end
				lsag_pkg::ANIM_SNAKE: begin
					off_q <= (off_q == OFF_W'(LED_COUNT - 1)) ? '0 : off_q + OFF_W'(1);
				end
				lsag_pkg::ANIM_SWAP: begin
					if (size_eff >= SZ_W'(2))
						cp_q <= cp_nx;
				end
				default: begin
				end
			endcase
		end
	end

	// fade: |to - from| * step, sign kept apart
	always_ff @(posedge clk) begin
		logic [7:0] f;
		logic [7:0] t;
		if (cmd.load)
			pix_q <= pixel_index;
		if (cmd.cap_from)
			from_q <= rdata_q;
		if (cmd.mul) begin
			for (int c = 0; c < 3; c++) begin
				f = from_q[8*c +: 8];
				t = rdata_q[8*c +: 8];
				dir_s1[c]  <= (t >= f);
				prod_s1[c] <= (t >= f) ? (8'(t - f) * j) : (8'(f - t) * j);
			end
			from_s1 <= from_q;
		end
	end

	always_comb begin
		dvd = '0;
		dvs = DW'(steps_eff);
		case (cmd.div_sel)
			lsag_pkg::DIV_SEGLEN: begin
				dvd[0] = DW'(LED_COUNT);
				dvs    = DW'(size_eff);
			end
			lsag_pkg::DIV_SEG: begin
				dvd[0] = DW'(rel);
				dvs    = quot[0];
			end
			default: begin
				for (int c = 0; c < 3; c++)
					dvd[c] = DW'(prod_s1[c]);
			end
		endcase
	end

	lsag_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quot),
		.busy     (div_busy)
	);

	always_comb begin
		logic [7:0] f;
		logic [7:0] q;
		for (int c = 0; c < 3; c++) begin
			f = from_s1[8*c +: 8];
			q = quot[c][7:0];
			fade_res[8*c +: 8] = dir_s1[c] ? f + q : f - q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			lsag_pkg::RES_ZERO:   res_q <= '0;
			lsag_pkg::RES_STATIC: res_q <= cfg.static_color;
			lsag_pkg::RES_RAM:    res_q <= rdata_q;
			lsag_pkg::RES_FADE:   res_q <= fade_res;
			default:              res_q <= res_q;
		endcase
		if (cmd.out_load) begin
			red_q   <= res_q[23:16];
			green_q <= res_q[15:8];
			blue_q  <= res_q[7:0];
		end
	end

	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;
endmodule

[hw/rtl/lsag_ctrl.sv]
// Controller: sequences each transaction through the datapath and owns the handshakes.
`timescale 1ns / 1ps
module lsag_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_action,
	input  logic              out_ready,
	input  lsag_pkg::sts_t    sts,
	output logic              in_ready,
	output logic              out_valid,
	output lsag_pkg::cmd_t    cmd
);
	lsag_pkg::state_t state_q;
	lsag_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lsag_pkg::ST_IDLE: begin
				if (in_valid && in_action == lsag_pkg::ACT_QUERY)
					state_d = lsag_pkg::ST_DISPATCH;
			end
			lsag_pkg::ST_DISPATCH: begin
				case (sts.kind)
					lsag_pkg::K_FADE:  state_d = lsag_pkg::ST_FROM;
					lsag_pkg::K_SNAKE: state_d = lsag_pkg::ST_SEGLEN;
					lsag_pkg::K_SWAP:  state_d = lsag_pkg::ST_RDRES;
					default:           state_d = lsag_pkg::ST_DONE;
				endcase
			end
			lsag_pkg::ST_SEGLEN: if (!sts.div_busy) state_d = lsag_pkg::ST_SEGCHK;
			lsag_pkg::ST_SEGCHK: begin
				state_d = sts.seglen_zero ? lsag_pkg::ST_RDRES : lsag_pkg::ST_SEG;
			end
			lsag_pkg::ST_SEG:    if (!sts.div_busy) state_d = lsag_pkg::ST_RDRES;
			lsag_pkg::ST_FROM:   state_d = lsag_pkg::ST_TO;
			lsag_pkg::ST_TO:     state_d = lsag_pkg::ST_MUL;
			lsag_pkg::ST_MUL:    state_d = lsag_pkg::ST_FDIV;
			lsag_pkg::ST_FDIV:   if (!sts.div_busy) state_d = lsag_pkg::ST_DONE;
			lsag_pkg::ST_RDRES:  state_d = lsag_pkg::ST_DONE;
			lsag_pkg::ST_DONE:   if (out_free) state_d = lsag_pkg::ST_IDLE;
			default:             state_d = lsag_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = lsag_pkg::RD_ZERO;
		cmd.res_sel  = lsag_pkg::RES_HOLD;
		cmd.div_sel  = lsag_pkg::DIV_FADE;
		in_ready     = 1'b0;
		case (state_q)
			lsag_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_action)
						lsag_pkg::ACT_ADVANCE:   cmd.adv     = 1'b1;
						lsag_pkg::ACT_QUERY:     cmd.load    = 1'b1;
						lsag_pkg::ACT_PAL_WRITE: cmd.pal_wr  = 1'b1;
						default:                 cmd.restart = 1'b1;
					endcase
				end
			end
			lsag_pkg::ST_DISPATCH: begin
				case (sts.kind)
					lsag_pkg::K_STATIC: cmd.res_sel = lsag_pkg::RES_STATIC;
					lsag_pkg::K_FADE: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = lsag_pkg::RD_CP;
					end
					lsag_pkg::K_SNAKE: begin
						cmd.div_go  = 1'b1;
						cmd.div_sel = lsag_pkg::DIV_SEGLEN;
					end
					lsag_pkg::K_SWAP: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = lsag_pkg::RD_SWAP;
					end
					default: cmd.res_sel = lsag_pkg::RES_ZERO;
				endcase
			end
			lsag_pkg::ST_SEGCHK: begin
				if (sts.seglen_zero) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = lsag_pkg::RD_ZERO;
				end else begin
					cmd.div_go  = 1'b1;
					cmd.div_sel = lsag_pkg::DIV_SEG;
				end
			end
			lsag_pkg::ST_SEG: begin
				if (!sts.div_busy) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = lsag_pkg::RD_SEG;
				end
			end
			lsag_pkg::ST_FROM: begin
				cmd.cap_from = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = lsag_pkg::RD_NX;
			end
			lsag_pkg::ST_TO:  cmd.mul = 1'b1;
			lsag_pkg::ST_MUL: cmd.div_go = 1'b1;
			lsag_pkg::ST_FDIV: begin
				if (!sts.div_busy)
					cmd.res_sel = lsag_pkg::RES_FADE;
			end
			lsag_pkg::ST_RDRES: cmd.res_sel = lsag_pkg::RES_RAM;
			lsag_pkg::ST_DONE:  cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsag_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

[hw/rtl/led_strip_animation_generator_top.sv]
// Top level: configuration registers, controller and datapath of the LED animation generator.
`timescale 1ns / 1ps
// Frame advance, palette write and restart transactions may follow back to back. A pixel
// query occupies the block until its color is loaded into the output register. Fade and
// snake queries wait on the shared restoring divider, which yields one quotient bit per
// cycle over max(18, pixel sum width) bits; snake uses it twice (segment length, then
// segment number) unless the segment length is zero. The next transaction is taken while
// a finished color still waits in the output register.
module led_strip_animation_generator_top #(
	parameter int LED_COUNT     = 300,
	parameter int PALETTE_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	lsag_item_if.sink          item,
	lsag_result_if.source      result
);
	lsag_pkg::cfg_t cfg_q;
	lsag_pkg::cmd_t cmd;
	lsag_pkg::sts_t sts;
	logic           wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.animation    <= lsag_pkg::ANIM_OFF;
			cfg_q.palette_size <= 4'd7;
			cfg_q.fade_steps   <= 10'd100;
			cfg_q.static_color <= lsag_pkg::STATIC_RESET;
		end else if (wr) begin
			case (paddr[3:2])
				lsag_pkg::REG_ANIMATION:    cfg_q.animation    <= pwdata[2:0];
				lsag_pkg::REG_PALETTE_SIZE: cfg_q.palette_size <= pwdata[3:0];
				lsag_pkg::REG_FADE_STEPS:   cfg_q.fade_steps   <= pwdata[9:0];
				default:                    cfg_q.static_color <= pwdata[23:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			lsag_pkg::REG_ANIMATION:    prdata = 32'(cfg_q.animation);
			lsag_pkg::REG_PALETTE_SIZE: prdata = 32'(cfg_q.palette_size);
			lsag_pkg::REG_FADE_STEPS:   prdata = 32'(cfg_q.fade_steps);
			default:                    prdata = 32'(cfg_q.static_color);
		endcase
	end

	lsag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_action (item.action),
		.out_ready (result.ready),
		.sts       (sts),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	lsag_dp #(
		.LED_COUNT     (LED_COUNT),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.pixel_index   (item.pixel_index),
		.palette_slot  (item.palette_slot),
		.palette_color (item.palette_color),
		.sts           (sts),
		.red           (result.red),
		.green         (result.green),
		.blue          (result.blue)
	);

	a_nonquery_stays_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.action != lsag_pkg::ACT_QUERY) |=> item.ready)
		else $error("non-query transaction left the block busy");

	a_query_busies: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.action == lsag_pkg::ACT_QUERY) |=> !item.ready)
		else $error("query transaction did not occupy the block");

	a_result_needs_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!item.ready))
		else $error("result appeared without a query in progress");
endmodule

[verif/tb.sv]
// Testbench for the LED strip animation generator: predicted pixel colors checked per transaction.
`timescale 1ns / 1ps
class color_scoreboard;
	logic [23:0] pending[$];
	int errors;
	int shown;

	function void note_query(logic [23:0] c);
		pending.push_back(c);
	endfunction

	function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		logic [23:0] e;
		if (pending.size() == 0) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("unexpected color %02h%02h%02h", r, g, b);
			end
			return;
		end
		e = pending.pop_front();
		if (e[23:16] !== r || e[15:8] !== g || e[7:0] !== b) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("color mismatch: expected %06h actual %02h%02h%02h", e, r, g, b);
			end
		end
	endfunction
endclass

module tb;
	localparam int LEDS = 300;
	localparam int DEPTH = 8;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int cycles;
	bit stall_on;

	lsag_item_if item ();
	lsag_result_if result ();

	led_strip_animation_generator_top #(.LED_COUNT(LEDS), .PALETTE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item(item.sink), .result(result.source)
	);

	color_scoreboard sb;

	logic [2:0]  anim;
	logic [3:0]  pal_size;
	logic [9:0]  steps;
	logic [23:0] stat_col;
	logic [23:0] palette[DEPTH];
	logic [2:0]  cpos;
	logic [9:0]  fpos;
	logic [8:0]  offset;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n)
			result.ready <= 0;
		else if (stall_on)
			result.ready <= ($urandom_range(0, 3) != 0);
		else
			result.ready <= 1;
	end

	always @(posedge clk)
		if (arst_n && result.valid && result.ready)
			sb.check_color(result.red, result.green, result.blue);

	function automatic int size_eff();
		if (pal_size == 0) return 1;
		if (pal_size > DEPTH) return DEPTH;
		return pal_size;
	endfunction

	function automatic int steps_eff();
		return steps == 0 ? 1 : steps;
	endfunction

	function automatic logic [7:0] blend(int f, int t, int j, int s);
		if (t >= f) return f + ((t - f) * j) / s;
		return f - ((f - t) * j) / s;
	endfunction

	function automatic logic [23:0] pixel_color(int p);
		int sz, s, cp, nx, j, len, rel, seg;
		logic [23:0] a, b;
		sz = size_eff();
		if (p >= LEDS) return 0;
		case (anim)
			lsag_pkg::ANIM_STATIC: return stat_col;
			lsag_pkg::ANIM_FADE: begin
				s = steps_eff();
				cp = cpos < sz ? cpos : 0;
				nx = (cp + 1) % sz;
				a = palette[cp];
				b = palette[nx];
				j = fpos > s ? s : fpos;
				return {blend(a[23:16], b[23:16], j, s), blend(a[15:8], b[15:8], j, s),
					blend(a[7:0], b[7:0], j, s)};
			end
			lsag_pkg::ANIM_SNAKE: begin
				len = LEDS / sz;
				if (len == 0) return palette[0];
				rel = (p + LEDS - offset) % LEDS;
				seg = rel / len;
				return seg >= sz ? palette[0] : palette[seg];
			end
			lsag_pkg::ANIM_SWAP: begin
				if (sz < 2) return palette[0];
				return palette[cpos < sz ? cpos : 0];
			end
			default: return 0;
		endcase
	endfunction

	function automatic void predict(lsag_pkg::action_t a, int p, int slot, logic [23:0] col);
		int sz;
		sz = size_eff();
		case (a)
			lsag_pkg::ACT_ADVANCE: begin
				if (anim == lsag_pkg::ANIM_FADE) begin
					fpos = fpos + 1;
					if (fpos > steps_eff() || fpos == 0) begin
						fpos = 1;
						cpos = (cpos + 1 >= sz) ? 0 : cpos + 1;
					end
				end else if (anim == lsag_pkg::ANIM_SNAKE) begin
					offset = (offset + 1) % LEDS;
				end else if (anim == lsag_pkg::ANIM_SWAP && sz >= 2) begin
					cpos = (cpos + 1 >= sz) ? 0 : cpos + 1;
				end
			end
			lsag_pkg::ACT_QUERY: sb.note_query(pixel_color(p));
			lsag_pkg::ACT_PAL_WRITE: if (slot < DEPTH) palette[slot] = col;
			default: begin
				cpos = 0;
				fpos = 1;
				offset = 0;
			end
		endcase
	endfunction

	task automatic reg_write(logic [1:0] idx, logic [31:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			lsag_pkg::REG_ANIMATION: anim = v[2:0];
			lsag_pkg::REG_PALETTE_SIZE: pal_size = v[3:0];
			lsag_pkg::REG_FADE_STEPS: steps = v[9:0];
			default: stat_col = v[23:0];
		endcase
	endtask

	task automatic drain();
		item.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic configure(logic [2:0] a, logic [3:0] sz, logic [9:0] st, logic [23:0] sc);
		drain();
		reg_write(lsag_pkg::REG_ANIMATION, a);
		reg_write(lsag_pkg::REG_PALETTE_SIZE, sz);
		reg_write(lsag_pkg::REG_FADE_STEPS, st);
		reg_write(lsag_pkg::REG_STATIC_COLOR, sc);
	endtask

	task automatic send(lsag_pkg::action_t a, logic [8:0] p, logic [2:0] slot,
		logic [23:0] col);
		item.valid <= 1;
		item.action <= a;
		item.pixel_index <= p;
		item.palette_slot <= slot;
		item.palette_color <= col;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		predict(a, p, slot, col);
	endtask

	task automatic gap();
		item.valid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic random_run(int count);
		int burst;
		lsag_pkg::action_t a;
		while (count > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && count > 0) begin
				a = lsag_pkg::action_t'($urandom_range(0, 9) < 4 ? lsag_pkg::ACT_QUERY :
					$urandom_range(0, 9) < 7 ? lsag_pkg::ACT_ADVANCE :
					$urandom_range(0, 3) == 0 ? lsag_pkg::ACT_RESTART :
					lsag_pkg::ACT_PAL_WRITE);
				send(a, $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) :
					$urandom_range(0, LEDS - 1), $urandom_range(0, 7),
					$urandom_range(0, 24'hFFFFFF));
				burst--;
				count--;
			end
			if ($urandom_range(0, 2) != 0) gap();
		end
		item.valid <= 0;
	endtask

	initial begin
		sb = new();
		cycles = 0;
		stall_on = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		item.valid = 0;
		item.action = lsag_pkg::ACT_ADVANCE;
		item.pixel_index = 0;
		item.palette_slot = 0;
		item.palette_color = 0;
		anim = lsag_pkg::ANIM_OFF;
		pal_size = 7;
		steps = 100;
		stat_col = lsag_pkg::STATIC_RESET;
		for (int i = 0; i < DEPTH; i++) palette[i] = lsag_pkg::pal_reset(i);
		cpos = 0;
		fpos = 1;
		offset = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset state, each animation, pixel and slot extremes
		send(lsag_pkg::ACT_QUERY, 0, 0, 0);
		send(lsag_pkg::ACT_QUERY, 9'h1FF, 0, 0);
		send(lsag_pkg::ACT_ADVANCE, 0, 0, 0);
		configure(lsag_pkg::ANIM_STATIC, 7, 100, 24'hFFFFFF);
		send(lsag_pkg::ACT_QUERY, 299, 7, 24'hFFFFFF);
		send(lsag_pkg::ACT_PAL_WRITE, 0, 7, 24'hFFFFFF);
		send(lsag_pkg::ACT_PAL_WRITE, 0, 0, 24'h000000);
		configure(lsag_pkg::ANIM_FADE, 8, 1, 0);
		send(lsag_pkg::ACT_QUERY, 5, 0, 0);
		send(lsag_pkg::ACT_ADVANCE, 0, 0, 0);
		send(lsag_pkg::ACT_QUERY, 300, 0, 0);
		send(lsag_pkg::ACT_QUERY, 5, 0, 0);
		configure(lsag_pkg::ANIM_SNAKE, 0, 0, 24'h123456);
		send(lsag_pkg::ACT_ADVANCE, 0, 0, 0);
		send(lsag_pkg::ACT_QUERY, 0, 0, 0);
		configure(lsag_pkg::ANIM_SNAKE, 15, 1023, 0);
		send(lsag_pkg::ACT_QUERY, 299, 0, 0);
		send(lsag_pkg::ACT_QUERY, 1, 0, 0);
		configure(lsag_pkg::ANIM_SWAP, 1, 1023, 0);
		send(lsag_pkg::ACT_ADVANCE, 0, 0, 0);
		send(lsag_pkg::ACT_QUERY, 2, 0, 0);
		configure(lsag_pkg::ANIM_SWAP, 3, 5, 0);
		send(lsag_pkg::ACT_ADVANCE, 0, 0, 0);
		send(lsag_pkg::ACT_QUERY, 2, 0, 0);
		send(lsag_pkg::ACT_RESTART, 0, 0, 0);
		send(lsag_pkg::ACT_QUERY, 2, 0, 0);
		configure(3'd7, 4, 5, 0);
		send(lsag_pkg::ACT_QUERY, 2, 0, 0);
		item.valid <= 0;

		// random phases over several settings; color position beyond size via size shrink
		for (int ph = 0; ph < 10; ph++) begin
			stall_on = ph % 3 != 0;
			configure(ph < 8 ? ph % 5 : $urandom_range(0, 7), $urandom_range(0, 15),
				ph == 3 ? 10'd1023 : $urandom_range(0, 12), $urandom_range(0, 24'hFFFFFF));
			random_run(80);
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

[files.f]
hw/rtl/lsag_pkg.sv
hw/rtl/lsag_item_if.sv
hw/rtl/lsag_result_if.sv
hw/rtl/lsag_div.sv
hw/rtl/lsag_dp.sv
hw/rtl/lsag_ctrl.sv
hw/rtl/led_strip_animation_generator_top.sv
verif/tb.sv
